>>> design/fvn_pkg.sv
`timescale 1ns / 1ps
package fvn_pkg;

    localparam int MAX_OCTAVES = 8;
    localparam int OCT_W       = 4;
    localparam int CRD_W       = 24;   // 8 lattice bits + 16 fraction bits
    localparam int ACC_W       = 32;

    // APB register addresses (byte offsets)
    localparam logic [3:0] ADDR_FREQ    = 4'h0;
    localparam logic [3:0] ADDR_OCTAVES = 4'h4;
    localparam logic [3:0] ADDR_SEED    = 4'h8;

    typedef struct packed {
        logic               vld;
        logic [CRD_W-1:0]   cx;
        logic [CRD_W-1:0]   cy;
        logic [ACC_W-1:0]   acc;
    } fvn_lane_t;

    localparam logic [7:0] PERM_TAB [0:255] = '{
        8'd208, 8'd34, 8'd231, 8'd213, 8'd32, 8'd248, 8'd233, 8'd56, 8'd161, 8'd78,
        8'd24, 8'd140, 8'd71, 8'd48, 8'd140, 8'd254, 8'd245, 8'd255, 8'd247, 8'd247,
        8'd40, 8'd185, 8'd248, 8'd251, 8'd245, 8'd28, 8'd124, 8'd204, 8'd204, 8'd76,
        8'd36, 8'd1, 8'd107, 8'd28, 8'd234, 8'd163, 8'd202, 8'd224, 8'd245, 8'd128,
        8'd167, 8'd204, 8'd9, 8'd92, 8'd217, 8'd54, 8'd239, 8'd174, 8'd173, 8'd102,
        8'd193, 8'd189, 8'd190, 8'd121, 8'd100, 8'd108, 8'd167, 8'd44, 8'd43, 8'd77,
        8'd180, 8'd204, 8'd8, 8'd81, 8'd70, 8'd223, 8'd11, 8'd38, 8'd24, 8'd254,
        8'd210, 8'd210, 8'd177, 8'd32, 8'd81, 8'd195, 8'd243, 8'd125, 8'd8, 8'd169,
        8'd112, 8'd32, 8'd97, 8'd53, 8'd195, 8'd13, 8'd203, 8'd9, 8'd47, 8'd104,
        8'd125, 8'd117, 8'd114, 8'd124, 8'd165, 8'd203, 8'd181, 8'd235, 8'd193, 8'd206,
        8'd70, 8'd180, 8'd174, 8'd0, 8'd167, 8'd181, 8'd41, 8'd164, 8'd30, 8'd116,
        8'd127, 8'd198, 8'd245, 8'd146, 8'd87, 8'd224, 8'd149, 8'd206, 8'd57, 8'd4,
        8'd192, 8'd210, 8'd65, 8'd210, 8'd129, 8'd240, 8'd178, 8'd105, 8'd228, 8'd108,
        8'd245, 8'd148, 8'd140, 8'd40, 8'd35, 8'd195, 8'd38, 8'd58, 8'd65, 8'd207,
        8'd215, 8'd253, 8'd65, 8'd85, 8'd208, 8'd76, 8'd62, 8'd3, 8'd237, 8'd55,
        8'd89, 8'd232, 8'd50, 8'd217, 8'd64, 8'd244, 8'd157, 8'd199, 8'd121, 8'd252,
        8'd90, 8'd17, 8'd212, 8'd203, 8'd149, 8'd152, 8'd140, 8'd187, 8'd234, 8'd177,
        8'd73, 8'd174, 8'd193, 8'd100, 8'd192, 8'd143, 8'd97, 8'd53, 8'd145, 8'd135,
        8'd19, 8'd103, 8'd13, 8'd90, 8'd135, 8'd151, 8'd199, 8'd91, 8'd239, 8'd247,
        8'd33, 8'd39, 8'd145, 8'd101, 8'd120, 8'd99, 8'd3, 8'd186, 8'd86, 8'd99,
        8'd41, 8'd237, 8'd203, 8'd111, 8'd79, 8'd220, 8'd135, 8'd158, 8'd42, 8'd30,
        8'd154, 8'd120, 8'd67, 8'd87, 8'd167, 8'd135, 8'd176, 8'd183, 8'd191, 8'd253,
        8'd115, 8'd184, 8'd21, 8'd233, 8'd58, 8'd129, 8'd233, 8'd142, 8'd39, 8'd128,
        8'd211, 8'd118, 8'd137, 8'd139, 8'd255, 8'd114, 8'd20, 8'd218, 8'd113, 8'd154,
        8'd27, 8'd127, 8'd246, 8'd250, 8'd1, 8'd8, 8'd198, 8'd250, 8'd209, 8'd92,
        8'd222, 8'd173, 8'd21, 8'd88, 8'd102, 8'd219
    };

    function automatic logic [7:0] perm(input logic [7:0] idx);
        return PERM_TAB[idx];
    endfunction

    // floor((2^32 - 1) / (2^d - 1)) for depth d
    function automatic logic [31:0] recip(input logic [OCT_W-1:0] d);
        logic [31:0] r;
        unique case (d)
            4'd1:    r = 32'd4294967295;
            4'd2:    r = 32'd1431655765;
            4'd3:    r = 32'd613566756;
            4'd4:    r = 32'd286331153;
            4'd5:    r = 32'd138547332;
            4'd6:    r = 32'd68174084;
            4'd7:    r = 32'd33818640;
            default: r = 32'd16843009;
        endcase
        return r;
    endfunction

endpackage

>>> design/fvn_cell.sv
`timescale 1ns / 1ps
// One octave: five stages, then acc = 2*acc + n when active.
module fvn_cell
    import fvn_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  logic      act,
    input  logic [7:0] seed,
    input  fvn_lane_t lane_in,
    output fvn_lane_t lane_out
);

    logic [3:0]  v_reg;
    logic [CRD_W-1:0] cx_reg [0:3];
    logic [CRD_W-1:0] cy_reg [0:3];
    logic [ACC_W-1:0] acc_reg [0:3];

    // stage 1
    logic [7:0]  xi1_reg, rowa1_reg, rowb1_reg;
    logic [15:0] fx1_reg, fy1_reg, tx1_reg, ty1_reg;
    // stage 2
    logic [16:0] wx2_reg, wy2_reg;
    logic [7:0]  c00_reg, c10_reg, c01_reg, c11_reg;
    // stage 3
    logic [24:0] l0_reg, l1_reg;
    logic [16:0] wy3_reg;
    // stage 4
    logic [41:0] p0_reg, p1_reg;
    // stage 5
    logic             out_vld_reg;
    logic [CRD_W-1:0] out_cx_reg, out_cy_reg;
    logic [ACC_W-1:0] out_acc_reg;

    logic [7:0]  yi, ys;
    logic [31:0] sqx, sqy;
    logic [17:0] kx, ky;
    logic [33:0] wxp, wyp;
    logic [7:0]  xi1p;
    logic [16:0] nwx, nwy;
    logic [42:0] psum;
    logic [23:0] n_val;

    always_comb
    begin
        yi   = lane_in.cy[23:16];
        ys   = yi + seed;
        sqx  = lane_in.cx[15:0] * lane_in.cx[15:0];
        sqy  = lane_in.cy[15:0] * lane_in.cy[15:0];
        kx   = 18'd196608 - {1'b0, fx1_reg, 1'b0};
        ky   = 18'd196608 - {1'b0, fy1_reg, 1'b0};
        wxp  = tx1_reg * kx;
        wyp  = ty1_reg * ky;
        xi1p = xi1_reg + 8'd1;
        nwx  = 17'd65536 - wx2_reg;
        nwy  = 17'd65536 - wy3_reg;
        psum = {1'b0, p0_reg} + {1'b0, p1_reg};
        n_val = psum[39:16];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg       <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg       <= {v_reg[2:0], lane_in.vld};
            out_vld_reg <= v_reg[3];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cx_reg[0]  <= lane_in.cx;
            cy_reg[0]  <= lane_in.cy;
            acc_reg[0] <= lane_in.acc;
            for (int k = 1; k < 4; k++)
            begin
                cx_reg[k]  <= cx_reg[k-1];
                cy_reg[k]  <= cy_reg[k-1];
                acc_reg[k] <= acc_reg[k-1];
            end

            xi1_reg   <= lane_in.cx[23:16];
            fx1_reg   <= lane_in.cx[15:0];
            fy1_reg   <= lane_in.cy[15:0];
            tx1_reg   <= sqx[31:16];
            ty1_reg   <= sqy[31:16];
            rowa1_reg <= perm(ys);
            rowb1_reg <= perm(ys + 8'd1);

            wx2_reg <= wxp[32:16];
            wy2_reg <= wyp[32:16];
            c00_reg <= perm(rowa1_reg + xi1_reg);
            c10_reg <= perm(rowa1_reg + xi1p);
            c01_reg <= perm(rowb1_reg + xi1_reg);
            c11_reg <= perm(rowb1_reg + xi1p);

            l0_reg  <= 25'(c00_reg * nwx) + 25'(c10_reg * wx2_reg);
            l1_reg  <= 25'(c01_reg * nwx) + 25'(c11_reg * wx2_reg);
            wy3_reg <= wy2_reg;

            p0_reg <= l0_reg * nwy;
            p1_reg <= l1_reg * wy3_reg;

            out_cx_reg  <= {cx_reg[3][CRD_W-2:0], 1'b0};
            out_cy_reg  <= {cy_reg[3][CRD_W-2:0], 1'b0};
            out_acc_reg <= act ? ({acc_reg[3][ACC_W-2:0], 1'b0} + ACC_W'(n_val))
                               : acc_reg[3];
        end
    end

    assign lane_out = '{vld: out_vld_reg, cx: out_cx_reg, cy: out_cy_reg, acc: out_acc_reg};

endmodule

>>> design/fvn_norm.sv
`timescale 1ns / 1ps
// acc / (256 * (2^d - 1)) by reciprocal and one correction, then grey.
module fvn_norm
    import fvn_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic [OCT_W-1:0] depth,
    input  fvn_lane_t        lane_in,
    output logic             vld,
    output logic [15:0]      noise,
    output logic [7:0]       grey
);

    logic [2:0]  v_reg;
    logic [23:0] a1_reg;
    logic [23:0] qe_reg;
    logic [15:0] q_reg;
    logic [15:0] noise_reg;
    logic [7:0]  grey_reg;

    logic [55:0] prod;
    logic [7:0]  k_div;
    logic [31:0] qk;
    logic [23:0] rem;
    logic [23:0] q_fix;
    logic [23:0] gprod;

    always_comb
    begin
        prod  = lane_in.acc[31:8] * recip(depth);
        k_div = 8'((9'd1 << depth) - 9'd1);
        qk    = qe_reg * k_div;
        rem   = a1_reg - qk[23:0];
        q_fix = qe_reg + ((rem >= 24'(k_div)) ? 24'd1 : 24'd0);
        gprod = q_reg * 8'd255;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[1:0], lane_in.vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg    <= lane_in.acc[31:8];
            qe_reg    <= prod[55:32];
            q_reg     <= q_fix[15:0];
            noise_reg <= q_reg;
            grey_reg  <= gprod[23:16];
        end
    end

    assign vld   = v_reg[2];
    assign noise = noise_reg;
    assign grey  = grey_reg;

endmodule

>>> design/fractal_value_noise_pixel.sv
`timescale 1ns / 1ps
// Pipeline: 1 scale stage, 8 octave cells of 5 stages each, 3 normalising stages,
//   whatever the octave count.
// Throughput: one item per cycle; the whole pipeline shares a single enable that
//   is held only while a result waits at the output and is not taken.
// Reset: rst_n asynchronous, active low; empties the pipeline and loads the
//   registers with freq 1.0, 4 octaves and seed 0.
module fractal_value_noise_pixel
    import fvn_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // x_coord[15:0], y_coord[31:16]
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // noise_q16[15:0], grey[23:16]
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [23:0]      freq_reg;
    logic [OCT_W-1:0] octaves_reg;
    logic [7:0]       seed_reg;

    logic             en;
    logic [OCT_W-1:0] depth;
    logic             wr;

    logic             pv_reg;
    logic [CRD_W-1:0] px_reg, py_reg;
    logic [39:0]      px_full, py_full;

    fvn_lane_t        lane [0:MAX_OCTAVES];

    logic             n_vld;
    logic [15:0]      n_noise;
    logic [7:0]       n_grey;

    // ---------------- configuration registers ----------------
    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_reg    <= 24'd65536;
            octaves_reg <= 4'd4;
            seed_reg    <= 8'd0;
        end
        else if (wr)
        begin
            unique case (paddr)
                ADDR_FREQ:    freq_reg    <= pwdata[23:0];
                ADDR_OCTAVES: octaves_reg <= pwdata[3:0];
                ADDR_SEED:    seed_reg    <= pwdata[7:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr)
            ADDR_FREQ:    prdata = {8'd0, freq_reg};
            ADDR_OCTAVES: prdata = {28'd0, octaves_reg};
            ADDR_SEED:    prdata = {24'd0, seed_reg};
            default:      prdata = '0;
        endcase
    end

    // zero octaves acts as one, anything past the cell count saturates
    always_comb
    begin
        priority if (octaves_reg == '0)
            depth = OCT_W'(1);
        else if (octaves_reg > OCT_W'(MAX_OCTAVES))
            depth = OCT_W'(MAX_OCTAVES);
        else
            depth = octaves_reg;
    end

    // ---------------- pipeline enable ----------------
    // every stage moves together; the output stage is the last register
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // ---------------- coordinate scaling ----------------
    // only the low 8 lattice bits and the 16 fraction bits matter downstream
    assign px_full = s_tdata[15:0]  * freq_reg;
    assign py_full = s_tdata[31:16] * freq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pv_reg <= 1'b0;
        else if (en)
            pv_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg <= px_full[CRD_W-1:0];
            py_reg <= py_full[CRD_W-1:0];
        end
    end

    assign lane[0].vld = pv_reg;
    assign lane[0].cx  = px_reg;
    assign lane[0].cy  = py_reg;
    assign lane[0].acc = '0;

    // ---------------- octave cells ----------------
    // cell i handles octave i and hands a doubled coordinate to the next; if i <
    // depth it folds its value into the running sum (Horner gives the 2^-i weights)
    for (genvar i = 0; i < MAX_OCTAVES; i++)
    begin : g_oct
        fvn_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .act      (OCT_W'(i) < depth),
            .seed     (seed_reg),
            .lane_in  (lane[i]),
            .lane_out (lane[i+1])
        );
    end

    // ---------------- normalise and output register ----------------
    fvn_norm u_norm (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .depth   (depth),
        .lane_in (lane[MAX_OCTAVES]),
        .vld     (n_vld),
        .noise   (n_noise),
        .grey    (n_grey)
    );

    assign m_tvalid = n_vld;
    assign m_tdata  = {n_grey, n_noise};

endmodule

>>> design/fvn_checker.sv
`timescale 1ns / 1ps
module fvn_checker
    import fvn_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        pready
);

    logic [23:0] gchk;
    assign gchk = m_tdata[15:0] * 8'd255;

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // input side is free whenever the output can move
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("input stalled without output back-pressure");

    a_grey: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[23:16] == gchk[23:16])
        else $error("grey does not match noise value");

    a_rst: assert property (@(posedge clk)
        !rst_n |=> !m_tvalid && pready)
        else $error("result shown during reset");

endmodule

bind fractal_value_noise_pixel fvn_checker u_fvn_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .pready   (pready)
);
